>>> design/rgb_to_vga_planar_dither_macros.svh
// Assertion helpers for the planar dither block.
`ifndef RGB_TO_VGA_PLANAR_DITHER_MACROS_SVH
`define RGB_TO_VGA_PLANAR_DITHER_MACROS_SVH
// Implication checked every cycle outside reset.
`define RVPD_ASSERT_IMP(label, clk, rst, a, b, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error(msg);
// Next-cycle implication checked outside reset.
`define RVPD_ASSERT_NEXT(label, clk, rst, a, b, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error(msg);
`endif

>>> design/rvpd_pkg.sv
// ----------------------------------------------------------------------------
// rvpd_pkg
// Shared types, constants and the dither pair table.
// ----------------------------------------------------------------------------
package rvpd_pkg;
   localparam int unsigned DitherEntries = 512;
   localparam logic [23:0] MonoPattern = 24'hFFEA80;
   localparam logic [23:0] MonoForced  = 24'hBBBBBB;
   localparam logic [0:0]  CsrMonoMode  = 1'b0;
   localparam logic [0:0]  CsrLineWidth = 1'b1;

   // one classified pixel, front to back
   typedef struct packed {
      logic [15:0] offset;
      logic [2:0]  pos;
      logic [3:0]  px;
      logic        eor;
   } pix_type;

   // one result item
   typedef struct packed {
      logic [15:0] offset;
      logic [7:0]  p0;
      logic [7:0]  p1;
      logic [7:0]  p2;
      logic [7:0]  p3;
      logic [7:0]  mask;
      logic        last;
   } rsp_type;

   localparam logic [7:0] PairTable [DitherEntries] = '{
8'h00,8'h04,8'h04,8'h0C,8'h44,8'h4C,8'h4C,8'hCC,8'h02,8'h06,8'h06,8'h2C,8'h46,8'h6C,8'h6C,8'hCC,
8'h02,8'h06,8'h06,8'h2C,8'h46,8'h6C,8'h6C,8'hCE,8'h0A,8'h4A,8'h4A,8'h0E,8'h0E,8'h4E,8'h4E,8'hCE,
8'h22,8'h26,8'h26,8'h0E,8'h66,8'h4E,8'h4E,8'hCE,8'h2A,8'h6A,8'h6A,8'h2E,8'h2E,8'h6E,8'h6E,8'hCE,
8'h2A,8'h6A,8'h6A,8'h2E,8'h2E,8'h6E,8'h6E,8'hEE,8'hAA,8'hAA,8'hAE,8'hAE,8'hAE,8'hAE,8'hEE,8'hEE,
8'h01,8'h05,8'h05,8'h1C,8'h45,8'h5C,8'h5C,8'hCC,8'h03,8'h08,8'h08,8'h3C,8'h48,8'h8C,8'h8C,8'hCC,
8'h03,8'h08,8'h08,8'h3C,8'h48,8'h8C,8'h8C,8'hCE,8'h1A,8'h5A,8'h5A,8'h1E,8'h1E,8'h5E,8'h5E,8'hCE,
8'h23,8'h28,8'h28,8'h1E,8'h68,8'h5E,8'h5E,8'hCE,8'h3A,8'h8A,8'h8A,8'h3E,8'h3E,8'h8E,8'h8E,8'hCE,
8'h3A,8'h8A,8'h8A,8'h3E,8'h3E,8'h8E,8'h8E,8'hEE,8'hAA,8'hAA,8'hAE,8'hAE,8'hAE,8'hAE,8'hEE,8'hEE,
8'h01,8'h05,8'h05,8'h1C,8'h45,8'h5C,8'h5C,8'hCD,8'h03,8'h08,8'h08,8'h3C,8'h48,8'h8C,8'h8C,8'hCD,
8'h03,8'h08,8'h08,8'h3C,8'h48,8'h8C,8'h8C,8'h7C,8'h1A,8'h5A,8'h5A,8'h07,8'h1E,8'h47,8'h5E,8'h7C,
8'h23,8'h28,8'h28,8'h1E,8'h68,8'h5E,8'h5E,8'h7C,8'h3A,8'h8A,8'h8A,8'h27,8'h3E,8'h8E,8'h8E,8'h7E,
8'h3A,8'h8A,8'h8A,8'h3E,8'h3E,8'h8E,8'h8E,8'h7E,8'hAB,8'hAB,8'h7A,8'h7A,8'h7A,8'h7E,8'h7E,8'h7E,
8'h09,8'h49,8'h49,8'h0D,8'h0D,8'h4D,8'h4D,8'hCD,8'h29,8'h69,8'h69,8'h2D,8'h2D,8'h6D,8'h6D,8'hCD,
8'h29,8'h69,8'h69,8'h07,8'h2D,8'h47,8'h6D,8'h7C,8'h0B,8'h4B,8'h07,8'h07,8'h47,8'h47,8'h7C,8'h7C,
8'h0B,8'h4B,8'h4B,8'h27,8'h0F,8'h67,8'h4F,8'hCF,8'h2B,8'h6B,8'h27,8'h27,8'h67,8'h67,8'h6F,8'hCF,
8'h2B,8'h6B,8'h6B,8'h7A,8'h2F,8'h6F,8'h7E,8'h7E,8'hAB,8'hAB,8'h7A,8'h7A,8'hAF,8'hAF,8'h7E,8'hEF,
8'h11,8'h15,8'h15,8'h0D,8'h55,8'h4D,8'h4D,8'hCD,8'h13,8'h18,8'h18,8'h2D,8'h58,8'h6D,8'h6D,8'hCD,
8'h13,8'h18,8'h18,8'h2D,8'h58,8'h6D,8'h6D,8'h7C,8'h0B,8'h4B,8'h4B,8'h17,8'h0F,8'h57,8'h4F,8'hCF,
8'h33,8'h38,8'h38,8'h0F,8'h88,8'h4F,8'h4F,8'hCF,8'h2B,8'h6B,8'h6B,8'h37,8'h2F,8'h78,8'h6F,8'hCF,
8'h2B,8'h6B,8'h6B,8'h2F,8'h2F,8'h6F,8'h6F,8'hEF,8'hAB,8'hAB,8'h7A,8'hAF,8'hAF,8'hAF,8'hEF,8'hEF,
8'h19,8'h59,8'h59,8'h1D,8'h1D,8'h5D,8'h5D,8'hCD,8'h39,8'h89,8'h89,8'h3D,8'h3D,8'h8D,8'h8D,8'hCD,
8'h39,8'h89,8'h89,8'h17,8'h3D,8'h8D,8'h8D,8'h7D,8'h1B,8'h5B,8'h17,8'h17,8'h57,8'h57,8'h5F,8'hCF,
8'h1B,8'h5B,8'h5B,8'h37,8'h1F,8'h78,8'h5F,8'hCF,8'h3B,8'h8B,8'h8B,8'h37,8'h78,8'h78,8'h8F,8'hCF,
8'h3B,8'h8B,8'h8B,8'h3F,8'h3F,8'h8F,8'h77,8'h7F,8'hAB,8'hAB,8'h7B,8'hAF,8'hAF,8'hAF,8'h7F,8'hEF,
8'h19,8'h59,8'h59,8'h1D,8'h1D,8'h5D,8'h5D,8'hDD,8'h39,8'h89,8'h89,8'h3D,8'h3D,8'h8D,8'h8D,8'hDD,
8'h39,8'h89,8'h89,8'h3D,8'h3D,8'h8D,8'h8D,8'h7D,8'h1B,8'h5B,8'h5B,8'h79,8'h1F,8'h5F,8'h7D,8'h7D,
8'h1B,8'h5B,8'h5B,8'h1F,8'h1F,8'h5F,8'h5F,8'hDF,8'h3B,8'h8B,8'h8B,8'h3F,8'h3F,8'h8F,8'h77,8'h7F,
8'h3B,8'h8B,8'h8B,8'h7B,8'h3F,8'h77,8'h77,8'h7F,8'hBB,8'hBB,8'h7B,8'h7B,8'hBF,8'h7F,8'h7F,8'h7F,
8'h99,8'h99,8'h9D,8'h9D,8'h9D,8'h9D,8'hDD,8'hDD,8'h99,8'h99,8'h9D,8'h9D,8'h9D,8'h9D,8'hDD,8'hDD,
8'h9B,8'h9B,8'h79,8'h79,8'h79,8'h7D,8'h7D,8'h7D,8'h9B,8'h9B,8'h79,8'h79,8'h9F,8'h9F,8'h7D,8'hDF,
8'h9B,8'h9B,8'h79,8'h9F,8'h9F,8'h9F,8'hDF,8'hDF,8'h9B,8'h9B,8'h7B,8'h9F,8'h9F,8'h9F,8'h7F,8'hDF,
8'hBB,8'hBB,8'h7B,8'h7B,8'hBF,8'h7F,8'h7F,8'h7F,8'hBB,8'hBB,8'h7B,8'hBF,8'hBF,8'hBF,8'h7F,8'hFF
   };
endpackage

>>> design/rvpd_front.sv
// ----------------------------------------------------------------------------
// rvpd_front
// Registered offset multiply and dither of one pixel per cycle.
// ----------------------------------------------------------------------------
module rvpd_front import rvpd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   input  logic [23:0] colour,
   input  logic [9:0]  pixel_x,
   input  logic [9:0]  pixel_y,
   input  logic        end_of_run,
   input  logic        mono_mode,
   input  logic [10:0] line_width,
   output logic        out_valid,
   output pix_type     out_pix
);
   logic        valid_ff;
   pix_type     pix_ff, pix_in;
   logic [20:0] prod;
   logic [8:0]  idx;
   logic [7:0]  pair;
   logic        par;
   logic [1:0]  phase;
   logic [4:0]  s;
   logic [23:0] sh;

   always_comb begin
      prod  = pixel_y * line_width;
      par   = pixel_x[0] ^ pixel_y[0];
      idx   = {colour[7:5], colour[15:13], colour[23:21]};
      pair  = PairTable[idx];
      phase = {pixel_y[0], 1'b0} + {1'b0, par};
      // 2R + 3G + B reaches 18, so five bits
      s     = {2'b0, colour[23:22], 1'b0} + {3'b0, colour[15:14]}
              + {2'b0, colour[15:14], 1'b0} + {3'b0, colour[7:6]};
      sh    = MonoPattern >> ({1'b0, s} + {4'b0, phase});
      pix_in.offset = 16'((prod + {11'b0, pixel_x}) >> 3);
      pix_in.pos    = pixel_x[2:0];
      pix_in.eor    = end_of_run;
      if (mono_mode) begin
         pix_in.px = {3'b0, (colour == MonoForced) | sh[0]};
      end else begin
         pix_in.px = par ? pair[3:0] : pair[7:4];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else       valid_ff <= in_valid;
      if (in_valid) pix_ff <= pix_in;
   end

   assign out_valid = valid_ff;
   assign out_pix   = pix_ff;
endmodule

>>> design/rvpd_queue.sv
// ----------------------------------------------------------------------------
// rvpd_queue
// Small FIFO of classified pixels.
// ----------------------------------------------------------------------------
module rvpd_queue import rvpd_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    wr,
   input  pix_type wdata,
   input  logic    rd,
   output logic    nonempty,
   output logic    room,
   output pix_type rdata
);
   // four slots; room drops at two so the item in the front stage still fits,
   // which keeps occupancy at three or below
   pix_type     mem [4];
   logic [2:0]  wp_ff, rp_ff, cnt;

   assign cnt      = wp_ff - rp_ff;
   assign nonempty = cnt != 3'd0;
   assign room     = cnt < 3'd2 || (cnt == 3'd2 && rd);
   assign rdata    = mem[rp_ff[1:0]];

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
      end else begin
         if (wr) wp_ff <= wp_ff + 3'd1;
         if (rd) rp_ff <= rp_ff + 3'd1;
      end
      if (wr) mem[wp_ff[1:0]] <= wdata;
   end
endmodule

>>> design/rvpd_back.sv
// ----------------------------------------------------------------------------
// rvpd_back
// Byte group gathering and result output queue.
// ----------------------------------------------------------------------------
module rvpd_back import rvpd_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   input  pix_type in_pix,
   input  logic    mono_mode,
   output logic    in_take,
   output logic    rsp_valid,
   output rsp_type rsp,
   input  logic    rsp_take
);
   logic [7:0]  planes_ff [4];
   logic [7:0]  mask_ff;
   logic [15:0] off_ff;
   rsp_type     q [4];
   logic [2:0]  wp_ff, rp_ff, cnt;
   logic        flush_old, flush_new;
   logic [7:0]  bitm, m2;
   logic [7:0]  np [4];
   rsp_type     r_old, r_new;

   assign cnt       = wp_ff - rp_ff;
   assign rsp_valid = cnt != 3'd0;
   assign rsp       = q[rp_ff[1:0]];
   assign in_take   = in_valid && cnt <= 3'd2;

   always_comb begin
      bitm      = 8'h80 >> in_pix.pos;
      flush_old = mask_ff != 8'h0 && in_pix.offset != off_ff;
      flush_new = in_pix.pos == 3'd7 || in_pix.eor;
      m2        = (flush_old ? 8'h0 : mask_ff) | bitm;
      for (int k = 0; k < 4; k++) begin
         np[k] = ((flush_old ? 8'h0 : planes_ff[k]) & ~bitm) | (in_pix.px[k] ? bitm : 8'h0);
      end
      r_old.offset = off_ff;
      r_old.p0 = planes_ff[0] & mask_ff;
      r_old.p1 = mono_mode ? 8'h0 : planes_ff[1] & mask_ff;
      r_old.p2 = mono_mode ? 8'h0 : planes_ff[2] & mask_ff;
      r_old.p3 = mono_mode ? 8'h0 : planes_ff[3] & mask_ff;
      r_old.mask = mask_ff;
      r_old.last = !flush_new;
      r_new.offset = in_pix.offset;
      r_new.p0 = np[0] & m2;
      r_new.p1 = mono_mode ? 8'h0 : np[1] & m2;
      r_new.p2 = mono_mode ? 8'h0 : np[2] & m2;
      r_new.p3 = mono_mode ? 8'h0 : np[3] & m2;
      r_new.mask = m2;
      r_new.last = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff   <= '0;
         rp_ff   <= '0;
         mask_ff <= '0;
         off_ff  <= '0;
         for (int k = 0; k < 4; k++) planes_ff[k] <= '0;
      end else begin
         if (rsp_take) rp_ff <= rp_ff + 3'd1;
         if (in_take) begin
            off_ff <= in_pix.offset;
            if (flush_new) begin
               mask_ff <= '0;
               for (int k = 0; k < 4; k++) planes_ff[k] <= '0;
            end else begin
               mask_ff <= m2;
               for (int k = 0; k < 4; k++) planes_ff[k] <= np[k];
            end
            wp_ff <= wp_ff + 3'(flush_old) + 3'(flush_new);
         end
      end
      if (in_take) begin
         if (flush_old) begin
            q[wp_ff[1:0]] <= r_old;
            if (flush_new) q[2'(wp_ff[1:0] + 2'd1)] <= r_new;
         end else if (flush_new) begin
            q[wp_ff[1:0]] <= r_new;
         end
      end
   end
endmodule

>>> design/rgb_to_vga_planar_dither.sv
// ----------------------------------------------------------------------------
// rgb_to_vga_planar_dither
// Ordered dither of RGB pixels into 4-plane byte groups.
// ----------------------------------------------------------------------------
// One pixel is taken per cycle while full is low. The front registers the byte
// offset product and the dithered color (table or mono pattern); a four-slot
// queue then feeds the back, which gathers groups of eight and writes up to
// two result items per pixel into a four-entry output queue. Sustained rate
// is one item per cycle while results are popped and each pixel ends at most
// one group; a pixel that ends two groups takes two result slots. A result
// passes the front register and both queues to the ports. full follows the
// pixel queue, which fills once the output queue backs up. The user must
// write registers only while nothing is in flight; no logic enforces it.
module rgb_to_vga_planar_dither import rvpd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [23:0] req_colour,
   input  logic [9:0]  req_pixel_x,
   input  logic [9:0]  req_pixel_y,
   input  logic        req_end_of_run,
   output logic        empty,
   input  logic        pop,
   output logic [15:0] rsp_byte_offset,
   output logic [7:0]  rsp_plane0_byte,
   output logic [7:0]  rsp_plane1_byte,
   output logic [7:0]  rsp_plane2_byte,
   output logic [7:0]  rsp_plane3_byte,
   output logic [7:0]  rsp_write_mask,
   output logic        rsp_last_of_run,
   input  logic        csr_we,
   input  logic [0:0]  csr_index,
   input  logic [10:0] csr_wdata
);
`include "rgb_to_vga_planar_dither_macros.svh"
   logic        mono_ff;
   logic [10:0] width_ff;
   logic        f_valid, q_ne, q_room, b_take, b_valid, acc;
   pix_type     f_pix, q_pix;
   rsp_type     r;

   always_ff @(posedge clock) begin
      if (reset) begin
         mono_ff  <= 1'b0;
         width_ff <= 11'd640;
      end else if (csr_we) begin
         unique case (csr_index)
            CsrMonoMode:  mono_ff  <= csr_wdata[0];
            CsrLineWidth: width_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // room already allows for the item still inside the front stage
   assign full = !q_room;
   assign acc  = push && !full;

   rvpd_front u_front (
      .clock, .reset, .in_valid(acc), .colour(req_colour), .pixel_x(req_pixel_x),
      .pixel_y(req_pixel_y), .end_of_run(req_end_of_run), .mono_mode(mono_ff),
      .line_width(width_ff), .out_valid(f_valid), .out_pix(f_pix)
   );

   rvpd_queue u_queue (
      .clock, .reset, .wr(f_valid), .wdata(f_pix), .rd(b_take),
      .nonempty(q_ne), .room(q_room), .rdata(q_pix)
   );

   rvpd_back u_back (
      .clock, .reset, .in_valid(q_ne), .in_pix(q_pix), .mono_mode(mono_ff),
      .in_take(b_take), .rsp_valid(b_valid), .rsp(r), .rsp_take(pop && b_valid)
   );

   assign empty           = !b_valid;
   assign rsp_byte_offset = r.offset;
   assign rsp_plane0_byte = r.p0;
   assign rsp_plane1_byte = r.p1;
   assign rsp_plane2_byte = r.p2;
   assign rsp_plane3_byte = r.p3;
   assign rsp_write_mask  = r.mask;
   assign rsp_last_of_run = r.last;

   `RVPD_ASSERT_IMP(a_no_push_full, clock, reset, full, !acc, "push taken while full")
   `RVPD_ASSERT_NEXT(a_front_valid, clock, reset, acc, f_valid, "front lost an item")
   `RVPD_ASSERT_IMP(a_mask_set, clock, reset, !empty, rsp_write_mask != 8'h0, "empty mask")
endmodule
